[rtl/swpt_pkg.sv]
package swpt_pkg;

   localparam int WINDOW_BLOCKS = 32;
   localparam int BLOCK_SIZE    = 8;
   localparam int CTU_BLOCKS    = 8;

   localparam int CELLS      = WINDOW_BLOCKS * WINDOW_BLOCKS;
   localparam int IDX_W      = $clog2(CELLS);
   localparam int COORD_W    = $clog2(WINDOW_BLOCKS);
   localparam int CELL_CNT_W = $clog2(CELLS + 1);
   localparam int BLK_W      = 9;
   localparam int ACC_W      = 48;
   localparam int MAP_W      = 12;
   localparam int MAP_OFFSET = (WINDOW_BLOCKS - CTU_BLOCKS) / 2;

   localparam logic [IDX_W-1:0]        LAST_IDX  = IDX_W'(CELLS - 1);
   localparam logic [ACC_W-1:0]        PIXELS    = ACC_W'(BLOCK_SIZE * BLOCK_SIZE);
   localparam logic [ACC_W-1:0]        CELLS_ACC = ACC_W'(CELLS);
   localparam logic [ACC_W-1:0]        ACC_ONE   = ACC_W'(1);
   localparam logic signed [MAP_W-1:0] MAP_OFF   = MAP_W'(MAP_OFFSET);
   localparam logic signed [MAP_W-1:0] MAP_LIMIT = MAP_W'(WINDOW_BLOCKS);
   localparam logic [BLK_W-1:0]        BLK_LIMIT = BLK_W'(WINDOW_BLOCKS);

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_X = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_Y = 1'b1;

   localparam logic [1:0] STATUS_MISS = 2'd0;
   localparam logic [1:0] STATUS_HIT  = 2'd1;
   localparam logic [1:0] STATUS_DONE = 2'd2;

   typedef enum logic [1:0] {
      REQ_READ  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_POWER = 2'd2,
      REQ_CLEAR = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      SQ_INIT,
      SQ_IDLE,
      SQ_SEARCH,
      SQ_SEARCH_END,
      SQ_WRITE,
      SQ_CLEAR,
      SQ_PREAD,
      SQ_PUPD,
      SQ_ACC,
      SQ_RESP
   } sq_state_type;

   typedef enum logic [2:0] {
      SEL_GATED,
      SEL_AWAKE,
      SEL_WAKE,
      SEL_STEP,
      SEL_READ,
      SEL_WRITE
   } acc_sel_type;

   typedef struct packed {
      logic             valid;
      logic [BLK_W-1:0] col;
      logic [BLK_W-1:0] row;
   } slot_entry_type;

   typedef struct packed {
      logic             wr_en;
      logic             rd_en;
      logic [IDX_W-1:0] addr;
      slot_entry_type   entry;
   } ss_cmd_type;

   typedef struct packed {
      logic             init_wr;
      logic             rd_en;
      logic             upd;
      logic             gate;
      logic [IDX_W-1:0] addr;
   } pm_cmd_type;

   typedef struct packed {
      logic start;
      logic add_read;
      logic add_write;
      logic add_wake;
      logic add_instant;
   } acc_cmd_type;

   typedef struct packed {
      logic [ACC_W-1:0] write_acc;
      logic [ACC_W-1:0] read_acc;
      logic [ACC_W-1:0] step_acc;
      logic [ACC_W-1:0] wake_acc;
      logic [ACC_W-1:0] awake_acc;
      logic [ACC_W-1:0] gated_acc;
   } acc_totals_type;

   function automatic logic [IDX_W-1:0] cell_index(input logic [COORD_W-1:0] c,
                                                   input logic [COORD_W-1:0] r);
      cell_index = IDX_W'(IDX_W'(c) * IDX_W'(WINDOW_BLOCKS) + IDX_W'(r));
   endfunction

endpackage

[rtl/scratchpad_window_power_tracker_unit.sv]
// Scratchpad window power tracker. One request item is taken at a time and
// answered by exactly one result item. After reset the block sweeps its slot
// and power memories, one entry per cycle, before req_tready first rises;
// CSR writes are taken during the sweep. A read walks the slot tag memory
// through its single read port, one slot per cycle, and ends early on a hit;
// a hit then passes through the accumulators. A clear writes every slot
// through the slot memory's write port. A write that falls outside the
// window goes straight to the result; a write inside it and a power update
// pass through the six accumulators, which share one 48-bit saturating
// adder, one accumulator per cycle. The result waits in its register until
// rsp_tready is high.
module scratchpad_window_power_tracker_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [swpt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [swpt_pkg::BLK_W-1:0]           csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // block_x [8:0], block_y [17:9], overlap [18], zero fill [23:19]
   input  logic [23:0]                          req_tdata,
   // req_type [1:0]
   input  logic [1:0]                           req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // gated_occupancy_total [47:0], awake_occupancy_total [95:48],
   // wake_total [143:96], time_steps [191:144], read_pixels [239:192],
   // write_pixels [287:240]
   output logic [287:0]                         rsp_tdata,
   // status [1:0]
   output logic [1:0]                           rsp_tuser
);

   swpt_pkg::sq_state_type           state_ff, state_in;
   logic [swpt_pkg::IDX_W-1:0]       cnt_ff, cnt_in;
   logic [1:0]                       status_ff, status_in;
   swpt_pkg::req_kind_type           kind_ff;
   logic [swpt_pkg::BLK_W-1:0]       bx_ff, by_ff;
   logic                             ov_ff;
   logic [swpt_pkg::BLK_W-1:0]       center_x_ff, center_y_ff;

   swpt_pkg::ss_cmd_type             ss_cmd;
   swpt_pkg::pm_cmd_type             pm_cmd;
   swpt_pkg::acc_cmd_type            acc_cmd;
   swpt_pkg::acc_totals_type         totals;
   logic                             match;
   logic                             wake;
   logic                             acc_busy;
   logic [swpt_pkg::CELL_CNT_W-1:0]  gated_cells;

   logic                             req_acc;
   logic                             last;
   logic signed [swpt_pkg::MAP_W-1:0] col_w, row_w;
   logic                             in_window;
   logic                             in_power_range;
   logic [swpt_pkg::IDX_W-1:0]       slot_idx, cell_idx;

   assign req_acc = req_tvalid && req_tready;
   assign last    = (cnt_ff == swpt_pkg::LAST_IDX);

   assign col_w = $signed({{(swpt_pkg::MAP_W - swpt_pkg::BLK_W){1'b0}}, bx_ff})
                - $signed({{(swpt_pkg::MAP_W - swpt_pkg::BLK_W){1'b0}}, center_x_ff})
                + swpt_pkg::MAP_OFF;
   assign row_w = $signed({{(swpt_pkg::MAP_W - swpt_pkg::BLK_W){1'b0}}, by_ff})
                - $signed({{(swpt_pkg::MAP_W - swpt_pkg::BLK_W){1'b0}}, center_y_ff})
                + swpt_pkg::MAP_OFF;
   assign in_window = (col_w >= $signed(swpt_pkg::MAP_W'(0))) &&
                      (col_w < swpt_pkg::MAP_LIMIT) &&
                      (row_w >= $signed(swpt_pkg::MAP_W'(0))) &&
                      (row_w < swpt_pkg::MAP_LIMIT);
   assign slot_idx = swpt_pkg::cell_index(col_w[swpt_pkg::COORD_W-1:0],
                                          row_w[swpt_pkg::COORD_W-1:0]);
   assign in_power_range = (bx_ff < swpt_pkg::BLK_LIMIT) && (by_ff < swpt_pkg::BLK_LIMIT);
   assign cell_idx = swpt_pkg::cell_index(bx_ff[swpt_pkg::COORD_W-1:0],
                                          by_ff[swpt_pkg::COORD_W-1:0]);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swpt_pkg::SQ_INIT: begin
            if (last) begin
               state_in = swpt_pkg::SQ_IDLE;
            end
         end
         swpt_pkg::SQ_IDLE: begin
            if (req_tvalid) begin
               case (swpt_pkg::req_kind_type'(req_tuser))
                  swpt_pkg::REQ_READ:  state_in = swpt_pkg::SQ_SEARCH;
                  swpt_pkg::REQ_WRITE: state_in = swpt_pkg::SQ_WRITE;
                  swpt_pkg::REQ_POWER: state_in = swpt_pkg::SQ_PREAD;
                  default:             state_in = swpt_pkg::SQ_CLEAR;
               endcase
            end
         end
         swpt_pkg::SQ_SEARCH: begin
            if (match) begin
               state_in = swpt_pkg::SQ_ACC;
            end else if (last) begin
               state_in = swpt_pkg::SQ_SEARCH_END;
            end
         end
         swpt_pkg::SQ_SEARCH_END: begin
            state_in = match ? swpt_pkg::SQ_ACC : swpt_pkg::SQ_RESP;
         end
         swpt_pkg::SQ_WRITE: begin
            state_in = in_window ? swpt_pkg::SQ_ACC : swpt_pkg::SQ_RESP;
         end
         swpt_pkg::SQ_CLEAR: begin
            if (last) begin
               state_in = swpt_pkg::SQ_RESP;
            end
         end
         swpt_pkg::SQ_PREAD: begin
            state_in = in_power_range ? swpt_pkg::SQ_PUPD : swpt_pkg::SQ_ACC;
         end
         swpt_pkg::SQ_PUPD: begin
            state_in = swpt_pkg::SQ_ACC;
         end
         swpt_pkg::SQ_ACC: begin
            if (!acc_busy) begin
               state_in = swpt_pkg::SQ_RESP;
            end
         end
         swpt_pkg::SQ_RESP: begin
            if (rsp_tready) begin
               state_in = swpt_pkg::SQ_IDLE;
            end
         end
         default: begin
            state_in = swpt_pkg::SQ_INIT;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cnt_in     = cnt_ff;
      status_in  = status_ff;
      ss_cmd     = '0;
      pm_cmd     = '0;
      acc_cmd    = '0;
      ss_cmd.entry.col = bx_ff;
      ss_cmd.entry.row = by_ff;
      pm_cmd.gate      = ov_ff;
      case (state_ff)
         swpt_pkg::SQ_INIT: begin
            ss_cmd.wr_en   = 1'b1;
            ss_cmd.addr    = cnt_ff;
            pm_cmd.init_wr = 1'b1;
            pm_cmd.addr    = cnt_ff;
            cnt_in         = last ? '0 : cnt_ff + 1'b1;
         end
         swpt_pkg::SQ_IDLE: begin
            req_tready = 1'b1;
            cnt_in     = '0;
            status_in  = (swpt_pkg::req_kind_type'(req_tuser) == swpt_pkg::REQ_READ) ?
                         swpt_pkg::STATUS_MISS : swpt_pkg::STATUS_DONE;
         end
         swpt_pkg::SQ_SEARCH: begin
            ss_cmd.rd_en = 1'b1;
            ss_cmd.addr  = cnt_ff;
            cnt_in       = last ? '0 : cnt_ff + 1'b1;
            if (match) begin
               status_in           = swpt_pkg::STATUS_HIT;
               acc_cmd.start       = 1'b1;
               acc_cmd.add_read    = 1'b1;
               acc_cmd.add_instant = 1'b1;
            end
         end
         swpt_pkg::SQ_SEARCH_END: begin
            if (match) begin
               status_in           = swpt_pkg::STATUS_HIT;
               acc_cmd.start       = 1'b1;
               acc_cmd.add_read    = 1'b1;
               acc_cmd.add_instant = 1'b1;
            end
         end
         swpt_pkg::SQ_WRITE: begin
            if (in_window) begin
               ss_cmd.wr_en       = 1'b1;
               ss_cmd.addr        = slot_idx;
               ss_cmd.entry.valid = 1'b1;
               acc_cmd.start      = 1'b1;
               acc_cmd.add_write  = 1'b1;
            end
         end
         swpt_pkg::SQ_CLEAR: begin
            ss_cmd.wr_en = 1'b1;
            ss_cmd.addr  = cnt_ff;
            cnt_in       = last ? '0 : cnt_ff + 1'b1;
         end
         swpt_pkg::SQ_PREAD: begin
            if (in_power_range) begin
               pm_cmd.rd_en = 1'b1;
               pm_cmd.addr  = cell_idx;
            end else begin
               acc_cmd.start       = 1'b1;
               acc_cmd.add_instant = 1'b1;
            end
         end
         swpt_pkg::SQ_PUPD: begin
            pm_cmd.upd          = 1'b1;
            pm_cmd.addr         = cell_idx;
            acc_cmd.start       = 1'b1;
            acc_cmd.add_instant = 1'b1;
            acc_cmd.add_wake    = wake;
         end
         swpt_pkg::SQ_RESP: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= swpt_pkg::SQ_INIT;
         cnt_ff    <= '0;
         status_ff <= swpt_pkg::STATUS_DONE;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         kind_ff <= swpt_pkg::req_kind_type'(req_tuser);
         bx_ff   <= req_tdata[8:0];
         by_ff   <= req_tdata[17:9];
         ov_ff   <= req_tdata[18];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            swpt_pkg::CSR_CENTER_X: center_x_ff <= csr_wdata;
            swpt_pkg::CSR_CENTER_Y: center_y_ff <= csr_wdata;
            default: begin
               center_x_ff <= center_x_ff;
            end
         endcase
      end
   end

   swpt_slot_store u_slot_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (ss_cmd),
      .key_col (bx_ff),
      .key_row (by_ff),
      .match   (match)
   );

   swpt_power_map u_power_map (
      .clock       (clock),
      .reset       (reset),
      .cmd         (pm_cmd),
      .gated_cells (gated_cells),
      .wake        (wake)
   );

   swpt_acc_unit u_acc_unit (
      .clock       (clock),
      .reset       (reset),
      .cmd         (acc_cmd),
      .gated_cells (gated_cells),
      .busy        (acc_busy),
      .totals      (totals)
   );

   assign rsp_tuser = status_ff;
   assign rsp_tdata = {totals.write_acc, totals.read_acc, totals.step_acc,
                       totals.wake_acc, totals.awake_acc, totals.gated_acc};

`ifndef SYNTHESIS
   a_one_side_open: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request and result sides open at once");

   a_gated_bound: assert property (@(posedge clock) disable iff (reset)
      gated_cells <= swpt_pkg::CELL_CNT_W'(swpt_pkg::CELLS))
      else $error("gated cell count exceeds window size");

   a_acc_only_in_acc: assert property (@(posedge clock) disable iff (reset)
      acc_busy |-> (state_ff == swpt_pkg::SQ_ACC))
      else $error("accumulator unit busy outside accounting");

   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == swpt_pkg::STATUS_HIT)) |-> (kind_ff == swpt_pkg::REQ_READ))
      else $error("hit status on a non-read item");

   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> req_tready)
      else $error("block not ready after result taken");
`endif

endmodule

[rtl/swpt_slot_store.sv]
module swpt_slot_store (
   input  logic                         clock,
   input  logic                         reset,
   input  swpt_pkg::ss_cmd_type         cmd,
   input  logic [swpt_pkg::BLK_W-1:0]   key_col,
   input  logic [swpt_pkg::BLK_W-1:0]   key_row,
   output logic                         match
);

   swpt_pkg::slot_entry_type slot_mem [swpt_pkg::CELLS];
   swpt_pkg::slot_entry_type rd_q_ff;
   logic                     rd_vld_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slot_mem[cmd.addr] <= cmd.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_q_ff <= slot_mem[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_en;
      end
   end

   assign match = rd_vld_ff && rd_q_ff.valid &&
                  (rd_q_ff.col == key_col) && (rd_q_ff.row == key_row);

endmodule

[rtl/swpt_power_map.sv]
module swpt_power_map (
   input  logic                              clock,
   input  logic                              reset,
   input  swpt_pkg::pm_cmd_type              cmd,
   output logic [swpt_pkg::CELL_CNT_W-1:0]   gated_cells,
   output logic                              wake
);

   logic                                 cell_mem [swpt_pkg::CELLS];
   logic                                 q_ff;
   logic [swpt_pkg::CELL_CNT_W-1:0]      gated_ff;
   logic                                 change;

   assign change = cmd.upd && (cmd.gate != q_ff);
   assign wake   = change && !cmd.gate;

   always_ff @(posedge clock) begin
      if (cmd.init_wr) begin
         cell_mem[cmd.addr] <= 1'b0;
      end else if (change) begin
         cell_mem[cmd.addr] <= cmd.gate;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         q_ff <= cell_mem[cmd.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gated_ff <= '0;
      end else if (change) begin
         if (cmd.gate) begin
            gated_ff <= gated_ff + 1'b1;
         end else begin
            gated_ff <= gated_ff - 1'b1;
         end
      end
   end

   assign gated_cells = gated_ff;

endmodule

[rtl/swpt_acc_unit.sv]
module swpt_acc_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  swpt_pkg::acc_cmd_type             cmd,
   input  logic [swpt_pkg::CELL_CNT_W-1:0]   gated_cells,
   output logic                              busy,
   output swpt_pkg::acc_totals_type          totals
);

   swpt_pkg::acc_sel_type       sel_ff, sel_in;
   logic                        busy_ff, busy_in;
   swpt_pkg::acc_cmd_type       en_ff;
   swpt_pkg::acc_totals_type    tot_ff, tot_in;
   logic [swpt_pkg::ACC_W-1:0]  op_a, op_b;
   logic                        op_en;
   logic [swpt_pkg::ACC_W:0]    sum;
   logic [swpt_pkg::ACC_W-1:0]  sat_sum;

   always_comb begin
      sel_in  = sel_ff;
      busy_in = busy_ff;
      if (cmd.start) begin
         sel_in  = swpt_pkg::SEL_GATED;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         case (sel_ff)
            swpt_pkg::SEL_GATED: sel_in = swpt_pkg::SEL_AWAKE;
            swpt_pkg::SEL_AWAKE: sel_in = swpt_pkg::SEL_WAKE;
            swpt_pkg::SEL_WAKE:  sel_in = swpt_pkg::SEL_STEP;
            swpt_pkg::SEL_STEP:  sel_in = swpt_pkg::SEL_READ;
            swpt_pkg::SEL_READ:  sel_in = swpt_pkg::SEL_WRITE;
            default: begin
               sel_in  = swpt_pkg::SEL_GATED;
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      case (sel_ff)
         swpt_pkg::SEL_GATED: begin
            op_a  = tot_ff.gated_acc;
            op_b  = swpt_pkg::ACC_W'(gated_cells);
            op_en = en_ff.add_instant;
         end
         swpt_pkg::SEL_AWAKE: begin
            op_a  = tot_ff.awake_acc;
            op_b  = swpt_pkg::CELLS_ACC - swpt_pkg::ACC_W'(gated_cells);
            op_en = en_ff.add_instant;
         end
         swpt_pkg::SEL_WAKE: begin
            op_a  = tot_ff.wake_acc;
            op_b  = swpt_pkg::ACC_ONE;
            op_en = en_ff.add_wake;
         end
         swpt_pkg::SEL_STEP: begin
            op_a  = tot_ff.step_acc;
            op_b  = swpt_pkg::ACC_ONE;
            op_en = en_ff.add_instant;
         end
         swpt_pkg::SEL_READ: begin
            op_a  = tot_ff.read_acc;
            op_b  = swpt_pkg::PIXELS;
            op_en = en_ff.add_read;
         end
         default: begin
            op_a  = tot_ff.write_acc;
            op_b  = swpt_pkg::PIXELS;
            op_en = en_ff.add_write;
         end
      endcase
      op_en   = op_en && busy_ff;
      sum     = {1'b0, op_a} + {1'b0, op_b};
      sat_sum = sum[swpt_pkg::ACC_W] ? '1 : sum[swpt_pkg::ACC_W-1:0];
      tot_in  = tot_ff;
      if (op_en) begin
         case (sel_ff)
            swpt_pkg::SEL_GATED: tot_in.gated_acc = sat_sum;
            swpt_pkg::SEL_AWAKE: tot_in.awake_acc = sat_sum;
            swpt_pkg::SEL_WAKE:  tot_in.wake_acc  = sat_sum;
            swpt_pkg::SEL_STEP:  tot_in.step_acc  = sat_sum;
            swpt_pkg::SEL_READ:  tot_in.read_acc  = sat_sum;
            default:             tot_in.write_acc = sat_sum;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff  <= swpt_pkg::SEL_GATED;
         busy_ff <= 1'b0;
         en_ff   <= '0;
         tot_ff  <= '0;
      end else begin
         sel_ff  <= sel_in;
         busy_ff <= busy_in;
         tot_ff  <= tot_in;
         if (cmd.start) begin
            en_ff <= cmd;
         end
      end
   end

   assign busy   = busy_ff;
   assign totals = tot_ff;

endmodule

[test/tb_top.sv]
module tb_top;

   localparam int HOLD_LEN   = 2000;
   localparam int RECENT_MAX = 48;

   typedef enum logic [1:0] {
      RX_STEADY,
      RX_COIN,
      RX_SPARSE
   } rx_mode_type;

   typedef struct {
      logic [1:0]   status;
      logic [287:0] totals;
   } tracker_report_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_wr_en;
   logic [swpt_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [swpt_pkg::BLK_W-1:0]       csr_wdata;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [23:0]                      req_tdata;
   logic [1:0]                       req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [287:0]                     rsp_tdata;
   logic [1:0]                       rsp_tuser;
   logic                             hold_request;

   scratchpad_window_power_tracker_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // tracker model state
   logic [swpt_pkg::BLK_W-1:0] tag_col [swpt_pkg::CELLS];
   logic [swpt_pkg::BLK_W-1:0] tag_row [swpt_pkg::CELLS];
   bit [swpt_pkg::CELLS-1:0]   tag_live;
   bit [swpt_pkg::CELLS-1:0]   cell_gated;
   int                         gated_count;
   logic [swpt_pkg::ACC_W-1:0] gated_sum, awake_sum, wake_sum, step_sum, read_sum, write_sum;
   logic [swpt_pkg::BLK_W-1:0] win_cx, win_cy;

   tracker_report_type  expected_reports [$];
   logic [17:0]         recent_tags [$];
   int                  failures;
   int                  burst_left;
   int                  n_hits, n_misses, n_writes, n_power, n_clears, n_centers;

   string field_names [6] = '{"gated_occupancy_total", "awake_occupancy_total",
                              "wake_total", "time_steps", "read_pixels",
                              "write_pixels"};

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #32_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [swpt_pkg::ACC_W-1:0] sat_add48(
         input logic [swpt_pkg::ACC_W-1:0] a,
         input logic [swpt_pkg::ACC_W-1:0] b);
      logic [swpt_pkg::ACC_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[swpt_pkg::ACC_W] ? '1 : s[swpt_pkg::ACC_W-1:0];
   endfunction

   function automatic void count_instant();
      gated_sum = sat_add48(gated_sum, swpt_pkg::ACC_W'(gated_count));
      awake_sum = sat_add48(awake_sum, swpt_pkg::ACC_W'(swpt_pkg::CELLS - gated_count));
      step_sum  = sat_add48(step_sum, swpt_pkg::ACC_ONE);
   endfunction

   function automatic tracker_report_type track_request(
         input swpt_pkg::req_kind_type kind,
         input logic [swpt_pkg::BLK_W-1:0] bx,
         input logic [swpt_pkg::BLK_W-1:0] by,
         input logic ov);
      tracker_report_type rep;
      int col, row, slot;
      bit hit;
      rep.status = swpt_pkg::STATUS_DONE;
      case (kind)
         swpt_pkg::REQ_READ: begin
            hit = 1'b0;
            for (int i = 0; i < swpt_pkg::CELLS && !hit; i++)
               if (tag_live[i] && tag_col[i] == bx && tag_row[i] == by) hit = 1'b1;
            rep.status = hit ? swpt_pkg::STATUS_HIT : swpt_pkg::STATUS_MISS;
            if (hit) begin
               read_sum = sat_add48(read_sum, swpt_pkg::PIXELS);
               count_instant();
               n_hits++;
            end else begin
               n_misses++;
            end
         end
         swpt_pkg::REQ_WRITE: begin
            col = int'(bx) - int'(win_cx) + swpt_pkg::MAP_OFFSET;
            row = int'(by) - int'(win_cy) + swpt_pkg::MAP_OFFSET;
            if (col >= 0 && col < swpt_pkg::WINDOW_BLOCKS &&
                row >= 0 && row < swpt_pkg::WINDOW_BLOCKS) begin
               slot = col * swpt_pkg::WINDOW_BLOCKS + row;
               tag_col[slot]  = bx;
               tag_row[slot]  = by;
               tag_live[slot] = 1'b1;
               write_sum = sat_add48(write_sum, swpt_pkg::PIXELS);
            end
            n_writes++;
         end
         swpt_pkg::REQ_POWER: begin
            if (bx < swpt_pkg::WINDOW_BLOCKS && by < swpt_pkg::WINDOW_BLOCKS) begin
               slot = int'(bx) * swpt_pkg::WINDOW_BLOCKS + int'(by);
               if (ov) begin
                  if (!cell_gated[slot]) begin
                     cell_gated[slot] = 1'b1;
                     gated_count++;
                  end
               end else if (cell_gated[slot]) begin
                  cell_gated[slot] = 1'b0;
                  gated_count--;
                  wake_sum = sat_add48(wake_sum, swpt_pkg::ACC_ONE);
               end
            end
            count_instant();
            n_power++;
         end
         default: begin
            tag_live = '0;
            n_clears++;
         end
      endcase
      rep.totals = {write_sum, read_sum, step_sum, wake_sum, awake_sum, gated_sum};
      return rep;
   endfunction

   task automatic send_item(input swpt_pkg::req_kind_type kind,
                            input logic [swpt_pkg::BLK_W-1:0] bx,
                            input logic [swpt_pkg::BLK_W-1:0] by, input logic ov);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, ov, by, bx};
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_reports.push_back(track_request(kind, bx, by, ov));
      if (kind == swpt_pkg::REQ_WRITE) begin
         recent_tags.push_back({by, bx});
         if (recent_tags.size() > RECENT_MAX) void'(recent_tags.pop_front());
      end
      burst_left--;
   endtask

   task automatic wait_all_reports();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (expected_reports.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_center(input logic [swpt_pkg::BLK_W-1:0] cx,
                               input logic [swpt_pkg::BLK_W-1:0] cy);
      csr_wr_en <= 1'b1;
      csr_index <= swpt_pkg::CSR_CENTER_X;
      csr_wdata <= cx;
      @(posedge clock);
      csr_index <= swpt_pkg::CSR_CENTER_Y;
      csr_wdata <= cy;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      win_cx = cx;
      win_cy = cy;
      n_centers++;
   endtask

   function automatic logic [swpt_pkg::BLK_W-1:0] near_window(
         input logic [swpt_pkg::BLK_W-1:0] center);
      return swpt_pkg::BLK_W'(int'(center) - swpt_pkg::MAP_OFFSET - 1 +
                              $urandom_range(0, swpt_pkg::WINDOW_BLOCKS + 1));
   endfunction

   task automatic send_random_item();
      int pick, r;
      logic [17:0] tag;
      logic [swpt_pkg::BLK_W-1:0] bx, by;
      pick = $urandom_range(0, 99);
      r    = $urandom_range(0, 9);
      bx   = swpt_pkg::BLK_W'($urandom_range(0, 511));
      by   = swpt_pkg::BLK_W'($urandom_range(0, 511));
      if (pick < 35) begin
         if (r < 6 && recent_tags.size() > 0) begin
            tag = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
            bx  = tag[8:0];
            by  = tag[17:9];
         end else if (r < 8) begin
            bx = near_window(win_cx);
            by = near_window(win_cy);
         end
         send_item(swpt_pkg::REQ_READ, bx, by, 1'($urandom_range(0, 1)));
      end else if (pick < 65) begin
         if (r < 8) begin
            bx = near_window(win_cx);
            by = near_window(win_cy);
         end
         send_item(swpt_pkg::REQ_WRITE, bx, by, 1'($urandom_range(0, 1)));
      end else if (pick < 96) begin
         if (r < 6) begin
            bx = swpt_pkg::BLK_W'($urandom_range(0, 7));
            by = swpt_pkg::BLK_W'($urandom_range(0, 7));
         end else if (r < 8) begin
            bx = swpt_pkg::BLK_W'($urandom_range(0, swpt_pkg::WINDOW_BLOCKS - 1));
            by = swpt_pkg::BLK_W'($urandom_range(0, swpt_pkg::WINDOW_BLOCKS - 1));
         end
         send_item(swpt_pkg::REQ_POWER, bx, by, 1'($urandom_range(0, 1)));
      end else begin
         send_item(swpt_pkg::REQ_CLEAR, bx, by, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_directed_cases();
      send_item(swpt_pkg::REQ_READ,  9'd0,   9'd0,   1'b0);
      send_item(swpt_pkg::REQ_WRITE, 9'd0,   9'd0,   1'b0);
      send_item(swpt_pkg::REQ_READ,  9'd0,   9'd0,   1'b0);
      send_item(swpt_pkg::REQ_WRITE, 9'd0,   9'd0,   1'b1);
      send_item(swpt_pkg::REQ_READ,  9'd0,   9'd0,   1'b1);
      send_item(swpt_pkg::REQ_WRITE, 9'd19,  9'd19,  1'b0);
      send_item(swpt_pkg::REQ_READ,  9'd19,  9'd19,  1'b0);
      send_item(swpt_pkg::REQ_WRITE, 9'd20,  9'd0,   1'b0);
      send_item(swpt_pkg::REQ_WRITE, 9'd0,   9'd20,  1'b0);
      send_item(swpt_pkg::REQ_WRITE, 9'd511, 9'd511, 1'b1);
      wait_all_reports();
      write_center(9'd20, 9'd20);
      send_item(swpt_pkg::REQ_WRITE, 9'd20,  9'd20,  1'b0);
      send_item(swpt_pkg::REQ_READ,  9'd0,   9'd0,   1'b0);
      send_item(swpt_pkg::REQ_WRITE, 9'd7,   9'd8,   1'b0);
      send_item(swpt_pkg::REQ_WRITE, 9'd19,  9'd19,  1'b0);
      send_item(swpt_pkg::REQ_WRITE, 9'd39,  9'd39,  1'b0);
      send_item(swpt_pkg::REQ_READ,  9'd19,  9'd19,  1'b0);
      send_item(swpt_pkg::REQ_READ,  9'd39,  9'd39,  1'b0);
      send_item(swpt_pkg::REQ_POWER, 9'd0,   9'd0,   1'b1);
      send_item(swpt_pkg::REQ_POWER, 9'd0,   9'd0,   1'b1);
      send_item(swpt_pkg::REQ_POWER, 9'd0,   9'd0,   1'b0);
      send_item(swpt_pkg::REQ_POWER, 9'd0,   9'd0,   1'b0);
      send_item(swpt_pkg::REQ_POWER, 9'd31,  9'd31,  1'b1);
      send_item(swpt_pkg::REQ_POWER, 9'd32,  9'd5,   1'b1);
      send_item(swpt_pkg::REQ_POWER, 9'd511, 9'd511, 1'b0);
      send_item(swpt_pkg::REQ_CLEAR, 9'd511, 9'd511, 1'b1);
      send_item(swpt_pkg::REQ_READ,  9'd39,  9'd39,  1'b0);
      wait_all_reports();
   endtask

   task automatic test_center_sweep();
      logic [swpt_pkg::BLK_W-1:0] xs [6] = '{9'd0, 9'd511, 9'd511, 9'd0, 9'd256, 9'd0};
      logic [swpt_pkg::BLK_W-1:0] ys [6] = '{9'd0, 9'd511, 9'd0, 9'd511, 9'd255, 9'd0};
      xs[5] = swpt_pkg::BLK_W'($urandom_range(0, 511));
      ys[5] = swpt_pkg::BLK_W'($urandom_range(0, 511));
      for (int p = 0; p < 6; p++) begin
         write_center(xs[p], ys[p]);
         repeat (50) send_random_item();
         wait_all_reports();
      end
   endtask

   task automatic test_output_stall();
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
      repeat (16) send_random_item();
      wait_all_reports();
   endtask

   task automatic test_random_mix();
      logic [swpt_pkg::BLK_W-1:0] cx, cy;
      for (int p = 0; p < 5; p++) begin
         if ($urandom_range(0, 1)) begin
            cx = win_cx + swpt_pkg::BLK_W'($urandom_range(0, 16)) - 9'd8;
            cy = win_cy + swpt_pkg::BLK_W'($urandom_range(0, 16)) - 9'd8;
         end else begin
            cx = swpt_pkg::BLK_W'($urandom_range(0, 511));
            cy = swpt_pkg::BLK_W'($urandom_range(0, 511));
         end
         write_center(cx, cy);
         repeat (48) send_random_item();
         wait_all_reports();
      end
   endtask

   initial begin : rsp_stall_pattern
      int hold_cnt, seg_left;
      rx_mode_type seg_mode;
      hold_cnt   = 0;
      seg_left   = 0;
      seg_mode   = RX_STEADY;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) hold_cnt = HOLD_LEN;
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_tready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_mode = rx_mode_type'($urandom_range(0, 2));
               seg_left = $urandom_range(5, 60);
            end
            seg_left--;
            case (seg_mode)
               RX_STEADY: rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               default:   rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_results
      tracker_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d",
                     $time, rsp_tuser);
            failures++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_tuser !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_tuser);
               failures++;
            end
            for (int f = 0; f < 6; f++)
               if (rsp_tdata[f*swpt_pkg::ACC_W +: swpt_pkg::ACC_W] !==
                   want.totals[f*swpt_pkg::ACC_W +: swpt_pkg::ACC_W]) begin
                  $display("%0t: %s mismatch, expected %0d, actual %0d", $time,
                           field_names[f],
                           want.totals[f*swpt_pkg::ACC_W +: swpt_pkg::ACC_W],
                           rsp_tdata[f*swpt_pkg::ACC_W +: swpt_pkg::ACC_W]);
                  failures++;
               end
         end
      end
   end

   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_index    = swpt_pkg::CSR_CENTER_X;
      csr_wdata    = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = swpt_pkg::REQ_READ;
      hold_request = 1'b0;
      failures     = 0;
      burst_left   = 0;
      tag_live     = '0;
      cell_gated   = '0;
      gated_count  = 0;
      gated_sum    = '0;
      awake_sum    = '0;
      wake_sum     = '0;
      step_sum     = '0;
      read_sum     = '0;
      write_sum    = '0;
      win_cx       = '0;
      win_cy       = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_center(9'd0, 9'd0);
      test_directed_cases();
      test_center_sweep();
      test_output_stall();
      test_random_mix();
      wait_all_reports();
      repeat (20) @(posedge clock);
      $display("Covered %0d read hits, %0d read misses, %0d writes, %0d power updates, %0d clears",
               n_hits, n_misses, n_writes, n_power, n_clears);
      $display("over %0d window center settings, including a %0d-cycle output stall",
               n_centers, HOLD_LEN);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
